FILE: rtl/owoi_pkg.sv
// ----------------------------------------------------------------------------
// owoi_pkg
// shared types and constants of the omni-wheel odometry integrator
// ----------------------------------------------------------------------------
package owoi_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int CORDIC_STAGES = 16;

  localparam logic [1:0] CFG_STEP_TIME    = 2'd0;
  localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd1;
  localparam logic [1:0] CFG_INV_BASE     = 2'd2;

  localparam logic signed [24:0] INV_SQRT3_Q24   = 25'sd9686330;
  localparam logic signed [24:0] ONE_THIRD_Q24   = 25'sd5592405;
  localparam logic signed [30:0] TURNS_PER_RAD   = 31'sd683565276;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] wheel0_speed;
    logic signed [31:0] wheel1_speed;
    logic signed [31:0] wheel2_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic        [31:0] heading_angle;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] yaw_rate;
    logic signed [17:0] quaternion_z;
    logic signed [17:0] quaternion_w;
  } out_item_t;

  // body speeds handed from the front part to the back part
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] yaw;
  } body_t;

  function automatic logic [31:0] atan_bam(input logic [3:0] i);
    logic [31:0] v;
    begin
      case (i)
        4'd0:  v = 32'd536870912;
        4'd1:  v = 32'd316933406;
        4'd2:  v = 32'd167458907;
        4'd3:  v = 32'd85004756;
        4'd4:  v = 32'd42667331;
        4'd5:  v = 32'd21354465;
        4'd6:  v = 32'd10679838;
        4'd7:  v = 32'd5340245;
        4'd8:  v = 32'd2670163;
        4'd9:  v = 32'd1335087;
        4'd10: v = 32'd667544;
        4'd11: v = 32'd333772;
        4'd12: v = 32'd166886;
        4'd13: v = 32'd83443;
        4'd14: v = 32'd41722;
        default: v = 32'd20861;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
        r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
        r = 32'sh8000_0000;
      end else begin
        r = v[31:0];
      end
      return r;
    end
  endfunction

endpackage

FILE: rtl/owoi_stream_if.sv
// ----------------------------------------------------------------------------
// owoi_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface owoi_stream_if #(parameter int WIDTH = 8);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/owoi_front.sv
// ----------------------------------------------------------------------------
// owoi_front
// forms body speeds from wheel speeds with one shared multiplier
// ----------------------------------------------------------------------------
module owoi_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  owoi_pkg::in_item_t         in_item,
  input  logic [15:0]                wheel_radius,
  input  logic [23:0]                inverse_base_radius,
  output logic                       body_valid,
  input  logic                       body_ready,
  output owoi_pkg::body_t            body
);
  import owoi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_VX1  = 3'd1;
  localparam logic [2:0] S_VX2  = 3'd2;
  localparam logic [2:0] S_VY1  = 3'd3;
  localparam logic [2:0] S_VY2  = 3'd4;
  localparam logic [2:0] S_U    = 3'd5;
  localparam logic [2:0] S_YAW  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic signed [33:0] w0_r, w1_r, w2_r;
  logic signed [63:0] t_r, t_nxt;
  logic signed [31:0] vx_r, vy_r, yaw_r;
  logic signed [63:0] vxn, vyn, yawn;
  logic signed [34:0] ma;
  logic signed [25:0] mb;
  logic signed [63:0] prod, rnd16, rnd24;

  assign prod  = ma * mb;
  assign rnd16 = (prod + 64'sd32768) >>> 16;
  assign rnd24 = (prod + 64'sd8388608) >>> 24;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_VX1: begin ma = 35'(w2_r - w0_r); mb = 26'({1'b0, wheel_radius}); end
      S_VX2: begin ma = 35'(t_r); mb = 26'(INV_SQRT3_Q24); end
      S_VY1: begin
        ma = 35'(w0_r + w2_r - (w1_r <<< 1));
        mb = 26'({1'b0, wheel_radius});
      end
      S_VY2: begin ma = 35'(t_r); mb = 26'(ONE_THIRD_Q24); end
      S_U:   begin ma = 35'(w1_r); mb = 26'({1'b0, wheel_radius}); end
      S_YAW: begin ma = 35'(t_r + 64'(vy_r)); mb = 26'({1'b0, inverse_base_radius}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    vxn       = 64'(vx_r);
    vyn       = 64'(vy_r);
    yawn      = 64'(yaw_r);
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_VX1;
      S_VX1:  begin t_nxt = rnd16; state_nxt = S_VX2; end
      S_VX2:  begin vxn = 64'(sat32(rnd24)); state_nxt = S_VY1; end
      S_VY1:  begin t_nxt = rnd16; state_nxt = S_VY2; end
      S_VY2:  begin vyn = 64'(sat32(rnd24)); state_nxt = S_U; end
      S_U:    begin t_nxt = rnd16; state_nxt = S_YAW; end
      S_YAW:  begin yawn = 64'(sat32(rnd16)); state_nxt = S_OUT; end
      S_OUT:  if (body_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      w0_r <= 34'(in_item.wheel0_speed);
      w1_r <= 34'(in_item.wheel1_speed);
      w2_r <= 34'(in_item.wheel2_speed);
    end
    t_r   <= t_nxt;
    vx_r  <= vxn[31:0];
    vy_r  <= vyn[31:0];
    yaw_r <= yawn[31:0];
  end

  assign in_ready   = (state_r == S_IDLE);
  assign body_valid = (state_r == S_OUT);
  assign body.vx    = vx_r;
  assign body.vy    = vy_r;
  assign body.yaw   = yaw_r;

endmodule

FILE: rtl/owoi_queue.sv
// ----------------------------------------------------------------------------
// owoi_queue
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module owoi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  owoi_pkg::body_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output owoi_pkg::body_t rd_data
);
  import owoi_pkg::*;

  body_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

FILE: rtl/owoi_back.sv
// ----------------------------------------------------------------------------
// owoi_back
// averages, rotates and integrates body speeds; cordic for heading terms
// ----------------------------------------------------------------------------
module owoi_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               body_valid,
  output logic               body_ready,
  input  owoi_pkg::body_t    body,
  input  logic [15:0]        step_time,
  output logic               res_valid,
  input  logic               res_ready,
  output owoi_pkg::out_item_t res
);
  import owoi_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_COR1  = 4'd1;
  localparam logic [3:0] S_RX1   = 4'd2;
  localparam logic [3:0] S_RX2   = 4'd3;
  localparam logic [3:0] S_RY1   = 4'd4;
  localparam logic [3:0] S_RY2   = 4'd5;
  localparam logic [3:0] S_DX    = 4'd6;
  localparam logic [3:0] S_DY    = 4'd7;
  localparam logic [3:0] S_INC1  = 4'd8;
  localparam logic [3:0] S_INC2  = 4'd9;
  localparam logic [3:0] S_COR2  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]         state_r, state_nxt;
  logic [3:0]         it_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic               flip_r;
  logic signed [31:0] px_r, py_r, avx_r, avy_r, yaw_r;
  logic [31:0]        head_r;
  logic signed [63:0] acc_r, dx_r, tmp_r;
  logic signed [33:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [33:0] c_q, s_q;
  logic signed [33:0] sx, sy;
  logic [31:0]        ang;
  logic               ang_flip;
  logic signed [63:0] r30, r16, rfb, qz, qw;

  assign prod = ma * mb;
  assign r30  = (acc_r + prod + 64'sd536870912) >>> 30;
  assign r16  = (prod + 64'sd32768) >>> 16;
  assign rfb  = (prod + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
  assign c_q  = flip_r ? -cx_r : cx_r;
  assign s_q  = flip_r ? -cy_r : cy_r;
  assign sx   = cx_r >>> it_r;
  assign sy   = cy_r >>> it_r;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_RX1: begin ma = 34'(avx_r); mb = c_q; end
      S_RX2: begin ma = -34'(avy_r); mb = s_q; end
      S_RY1: begin ma = 34'(avx_r); mb = s_q; end
      S_RY2: begin ma = 34'(avy_r); mb = c_q; end
      S_DX:  begin ma = 34'(dx_r); mb = 34'({1'b0, step_time}); end
      S_DY:  begin ma = 34'(tmp_r); mb = 34'({1'b0, step_time}); end
      S_INC1: begin ma = 34'(yaw_r); mb = 34'({1'b0, step_time}); end
      S_INC2: begin ma = 34'(tmp_r); mb = 34'(TURNS_PER_RAD); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    ang      = (state_r == S_INC2) ? ((head_r + rfb[31:0]) >> 1) : head_r;
    ang_flip = ang[31] ^ ang[30];
  end

  always_comb begin
    qz = (s_q + 34'sd8192) >>> 14;
    qw = (c_q + 34'sd8192) >>> 14;
    if (qz > 64'sd65536) qz = 64'sd65536;
    if (qz < -64'sd65536) qz = -64'sd65536;
    if (qw > 64'sd65536) qw = 64'sd65536;
    if (qw < -64'sd65536) qw = -64'sd65536;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (body_valid) state_nxt = S_COR1;
      S_COR1: if (it_r == 4'(CORDIC_STAGES - 1)) state_nxt = S_RX1;
      S_RX1:  state_nxt = S_RX2;
      S_RX2:  state_nxt = S_RY1;
      S_RY1:  state_nxt = S_RY2;
      S_RY2:  state_nxt = S_DX;
      S_DX:   state_nxt = S_DY;
      S_DY:   state_nxt = S_INC1;
      S_INC1: state_nxt = S_INC2;
      S_INC2: state_nxt = S_COR2;
      S_COR2: if (it_r == 4'(CORDIC_STAGES - 1)) state_nxt = S_OUT;
      S_OUT:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      px_r    <= '0;
      py_r    <= '0;
      head_r  <= '0;
      avx_r   <= '0;
      avy_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (body_valid) begin
          avx_r <= 32'((33'(body.vx) + 33'(avx_r)) >>> 1);
          avy_r <= 32'((33'(body.vy) + 33'(avy_r)) >>> 1);
        end
        S_DX:   px_r <= sat32(64'(px_r) + r16);
        S_DY:   py_r <= sat32(64'(py_r) + r16);
        S_INC2: head_r <= head_r + rfb[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r) inside
      S_IDLE: if (body_valid) yaw_r <= body.yaw;
      S_RX1, S_RY1: acc_r <= prod;
      S_RX2: begin dx_r <= r30; acc_r <= '0; end
      S_RY2: begin tmp_r <= r30; acc_r <= '0; end
      S_INC1: tmp_r <= r16;
      default: ;
    endcase
    if (state_r == S_IDLE || state_r == S_INC2) begin
      it_r   <= '0;
      cx_r   <= CORDIC_GAIN_Q30;
      cy_r   <= '0;
      flip_r <= ang_flip;
      cz_r   <= 33'(signed'(ang_flip ? (ang ^ 32'h8000_0000) : ang));
      if (state_r == S_IDLE) acc_r <= '0;
    end else if (state_r == S_COR1 || state_r == S_COR2) begin
      it_r <= it_r + 4'd1;
      if (!cz_r[32]) begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        cz_r <= cz_r - 33'({1'b0, atan_bam(it_r)});
      end else begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        cz_r <= cz_r + 33'({1'b0, atan_bam(it_r)});
      end
    end
  end

  assign body_ready        = (state_r == S_IDLE);
  assign res_valid         = (state_r == S_OUT);
  assign res.position_x    = px_r;
  assign res.position_y    = py_r;
  assign res.heading_angle = head_r;
  assign res.speed_x       = avx_r;
  assign res.speed_y       = avy_r;
  assign res.yaw_rate      = yaw_r;
  assign res.quaternion_z  = qz[17:0];
  assign res.quaternion_w  = qw[17:0];

endmodule

FILE: rtl/omni_wheel_odometry_integrator_top.sv
// ----------------------------------------------------------------------------
// omni_wheel_odometry_integrator_top
// three-wheel omni odometry: body speeds, averaging, rotation, integration
// ----------------------------------------------------------------------------
// the back part takes a new item only after its last result is taken; its pace
// is set by its two 16-step cordic passes and its shared multiplier, while the
// front, with the two-entry queue between the parts, overlaps the next item
// reset: pose, heading and averaged speeds clear to zero, registers to defaults
module omni_wheel_odometry_integrator_top (
  input  logic        clk,
  input  logic        rst_n,
  owoi_stream_if.sink   in_ch,
  owoi_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import owoi_pkg::*;

  logic [15:0] step_time_r, wheel_radius_r;
  logic [23:0] inv_base_r;
  logic        f_valid, f_ready, q_valid, q_ready;
  body_t       f_body, q_body;
  out_item_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r    <= 16'd655;
      wheel_radius_r <= 16'd2621;
      inv_base_r     <= 24'd496485;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_TIME:    step_time_r <= cfg_data[15:0];
        CFG_WHEEL_RADIUS: wheel_radius_r <= cfg_data[15:0];
        CFG_INV_BASE:     inv_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  owoi_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_item_t'(in_ch.data)),
    .wheel_radius(wheel_radius_r), .inverse_base_radius(inv_base_r),
    .body_valid(f_valid), .body_ready(f_ready), .body(f_body)
  );

  owoi_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_body),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_body)
  );

  owoi_back u_back (
    .clk, .rst_n,
    .body_valid(q_valid), .body_ready(q_ready), .body(q_body),
    .step_time(step_time_r),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.data = res;

endmodule
